FILE: sv/pcpf_pkg.sv
`timescale 1ns / 1ps
// Package of the pad cluster peak finder: item types, cluster state type,
// register indexes and the shared close and saturating-add functions. No dependencies.
package pcpf_pkg;

   localparam int CHARGE_BITS  = 24;
   localparam int ID_BITS      = 16;
   localparam int ROW_COL_BITS = 8;
   localparam int COUNT_BITS   = 8;
   localparam int SUM_BITS     = 32;
   localparam int KEEP_IDS     = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] KEEP_IDS_COUNT = COUNT_BITS'(KEEP_IDS);

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_MULTI_HIT = 1'b1;

   typedef struct packed {
      logic [ID_BITS-1:0]      pad_id;
      logic [ROW_COL_BITS-1:0] pad_row;
      logic [ROW_COL_BITS-1:0] pad_col;
      logic [CHARGE_BITS-1:0]  pad_charge;
      logic                    module_end;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  pad_count;
      logic [ID_BITS-1:0]     first_id;
      logic [ID_BITS-1:0]     second_id;
      logic [ID_BITS-1:0]     third_id;
      logic [SUM_BITS-1:0]    charge_total;
      logic [CHARGE_BITS-1:0] charge_peak;
      logic                   last_result;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } opt_result_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   typedef struct packed {
      logic                              open_valid;
      logic [ID_BITS-1:0]                cur_id;
      logic [ROW_COL_BITS-1:0]           cur_row;
      logic [ROW_COL_BITS-1:0]           cur_col;
      logic [CHARGE_BITS-1:0]            cur_charge;
      logic                              prev_valid;
      logic [ID_BITS-1:0]                prev_id;
      logic [CHARGE_BITS-1:0]            prev_charge;
      logic                              rising;
      logic [COUNT_BITS-1:0]             run_count;
      logic [SUM_BITS-1:0]               run_sum;
      logic [CHARGE_BITS-1:0]            run_max;
      logic [KEEP_IDS-1:0][ID_BITS-1:0]  first_ids;
   } cluster_state_type;

   localparam cluster_state_type CLUSTER_RESET = '{rising: 1'b1, default: '0};

   function automatic logic [SUM_BITS-1:0] widen_charge(logic [CHARGE_BITS-1:0] q);
      return SUM_BITS'(q);
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                                   logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
   endfunction

   function automatic opt_result_type close_result(cluster_state_type st, logic multi);
      opt_result_type r;
      r = '0;
      if (st.open_valid) begin
         if (multi) begin
            if (st.rising) begin
               r.valid = 1'b1;
               r.item.charge_peak = st.cur_charge;
               if (st.prev_valid) begin
                  r.item.pad_count    = COUNT_BITS'(2);
                  r.item.first_id     = st.prev_id;
                  r.item.second_id    = st.cur_id;
                  r.item.charge_total = sat_add(widen_charge(st.prev_charge),
                                                widen_charge(st.cur_charge));
               end else begin
                  r.item.pad_count    = COUNT_BITS'(1);
                  r.item.first_id     = st.cur_id;
                  r.item.charge_total = widen_charge(st.cur_charge);
               end
            end
         end else begin
            r.valid = 1'b1;
            r.item.pad_count    = st.run_count;
            r.item.first_id     = st.first_ids[0];
            r.item.second_id    = (st.run_count >= COUNT_BITS'(2)) ? st.first_ids[1] : '0;
            r.item.third_id     = (st.run_count >= COUNT_BITS'(3)) ? st.first_ids[2] : '0;
            r.item.charge_total = st.run_sum;
            r.item.charge_peak  = st.run_max;
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/pad_cluster_peak_finder.sv
`timescale 1ns / 1ps
// Pad cluster peak finder, top level. Depends on pcpf_pkg, pcpf_core and
// pcpf_out_queue.
//
// Pad hits, sorted by row and column, enter at one item per clock while req_ready
// is high. Each item is registered in the input register, then handled by the
// cluster logic, which writes zero, one or two result items into a result queue
// of OUT_DEPTH entries (a power of two, at least 2); rsp_valid for a result rises
// once its hit has passed the input register and its result is written into the
// queue. The queue hands out one result per clock while rsp_ready is high, so
// the two results of a hit leave it one after the other; req_ready drops while the
// queue has fewer than two free entries and the input register is full.
// Configuration writes must be made only while no item is in flight; they are
// not held off by the block.
module pad_cluster_peak_finder #(
   parameter int OUT_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pcpf_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pcpf_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_wen,
   input  logic                              csr_index,
   input  logic [pcpf_pkg::CHARGE_BITS-1:0]  csr_wdata
);

   pcpf_pkg::push_type push;
   logic               room_ok;

   pcpf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .room_ok   (room_ok),
      .push      (push)
   );

   pcpf_out_queue #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room_ok   (room_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: sv/pcpf_core.sv
`timescale 1ns / 1ps
// Input register, configuration registers, cluster state and result logic of the
// pad cluster peak finder. Depends on pcpf_pkg.
module pcpf_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pcpf_pkg::req_item_type              req_item,
   input  logic                                csr_wen,
   input  logic                                csr_index,
   input  logic [pcpf_pkg::CHARGE_BITS-1:0]    csr_wdata,
   input  logic                                room_ok,
   output pcpf_pkg::push_type                  push
);

   logic                              in_valid_ff, in_valid_in;
   pcpf_pkg::req_item_type            in_item_ff;
   logic [pcpf_pkg::CHARGE_BITS-1:0]  threshold_ff;
   logic                              multi_ff;
   pcpf_pkg::cluster_state_type       state_ff, state_in;
   pcpf_pkg::opt_result_type          first_r, second_r;
   pcpf_pkg::cluster_state_type       st1;
   logic                              advance, accept, kept, extend_c;
   logic [pcpf_pkg::ROW_COL_BITS:0]   next_col;
   logic [pcpf_pkg::SUM_BITS-1:0]     pair_sum;

   assign advance     = in_valid_ff & room_ok;
   assign req_ready   = ~in_valid_ff | room_ok;
   assign accept      = req_valid & req_ready;
   assign in_valid_in = accept | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         threshold_ff <= '0;
         multi_ff     <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               pcpf_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
               pcpf_pkg::CSR_MULTI_HIT: multi_ff     <= csr_wdata[0];
               default:                 threshold_ff <= threshold_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcpf_pkg::CLUSTER_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      next_col = {1'b0, state_ff.cur_col} + 1'b1;
      kept     = in_item_ff.pad_charge > threshold_ff;
      extend_c = state_ff.open_valid && (in_item_ff.pad_row == state_ff.cur_row)
                 && ({1'b0, in_item_ff.pad_col} == next_col);
      pair_sum = pcpf_pkg::sat_add(pcpf_pkg::widen_charge(state_ff.cur_charge),
                                   pcpf_pkg::widen_charge(in_item_ff.pad_charge));
      first_r  = '0;
      st1      = state_ff;
      if (kept) begin
         if (extend_c) begin
            if (multi_ff && state_ff.rising
                && (in_item_ff.pad_charge <= state_ff.cur_charge)) begin
               first_r.valid            = 1'b1;
               first_r.item.charge_peak = state_ff.cur_charge;
               if (state_ff.prev_valid) begin
                  first_r.item.pad_count    = pcpf_pkg::COUNT_BITS'(3);
                  first_r.item.first_id     = state_ff.prev_id;
                  first_r.item.second_id    = state_ff.cur_id;
                  first_r.item.third_id     = in_item_ff.pad_id;
                  first_r.item.charge_total = pcpf_pkg::sat_add(pair_sum,
                     pcpf_pkg::widen_charge(state_ff.prev_charge));
               end else begin
                  first_r.item.pad_count    = pcpf_pkg::COUNT_BITS'(2);
                  first_r.item.first_id     = state_ff.cur_id;
                  first_r.item.second_id    = in_item_ff.pad_id;
                  first_r.item.charge_total = pair_sum;
               end
            end
            st1.rising      = in_item_ff.pad_charge >= state_ff.cur_charge;
            st1.prev_valid  = 1'b1;
            st1.prev_id     = state_ff.cur_id;
            st1.prev_charge = state_ff.cur_charge;
            st1.cur_id      = in_item_ff.pad_id;
            st1.cur_col     = next_col[pcpf_pkg::ROW_COL_BITS-1:0];
            st1.cur_charge  = in_item_ff.pad_charge;
            if (state_ff.run_count < pcpf_pkg::KEEP_IDS_COUNT) begin
               st1.first_ids[state_ff.run_count[1:0]] = in_item_ff.pad_id;
            end
            if (state_ff.run_count < pcpf_pkg::COUNT_MAX) begin
               st1.run_count = state_ff.run_count + 1'b1;
            end
            st1.run_sum = pcpf_pkg::sat_add(state_ff.run_sum,
                                            pcpf_pkg::widen_charge(in_item_ff.pad_charge));
            if (in_item_ff.pad_charge > state_ff.run_max) begin
               st1.run_max = in_item_ff.pad_charge;
            end
         end else begin
            first_r         = pcpf_pkg::close_result(state_ff, multi_ff);
            st1.open_valid  = 1'b1;
            st1.cur_id      = in_item_ff.pad_id;
            st1.cur_row     = in_item_ff.pad_row;
            st1.cur_col     = in_item_ff.pad_col;
            st1.cur_charge  = in_item_ff.pad_charge;
            st1.prev_valid  = 1'b0;
            st1.prev_id     = '0;
            st1.prev_charge = '0;
            st1.rising      = 1'b1;
            st1.run_count   = pcpf_pkg::COUNT_BITS'(1);
            st1.run_sum     = pcpf_pkg::widen_charge(in_item_ff.pad_charge);
            st1.run_max     = in_item_ff.pad_charge;
            st1.first_ids   = '0;
            st1.first_ids[0] = in_item_ff.pad_id;
         end
      end
      second_r = '0;
      state_in = st1;
      if (in_item_ff.module_end) begin
         second_r            = pcpf_pkg::close_result(st1, multi_ff);
         state_in.open_valid = 1'b0;
      end
   end

   always_comb begin
      push = '0;
      if (advance) begin
         if (first_r.valid) begin
            push.first             = first_r.item;
            push.first.last_result = ~second_r.valid;
            push.second            = second_r.item;
            push.second.last_result = 1'b1;
            push.count             = second_r.valid ? 2'd2 : 2'd1;
         end else if (second_r.valid) begin
            push.first             = second_r.item;
            push.first.last_result = 1'b1;
            push.count             = 2'd1;
         end
      end
   end

endmodule

FILE: sv/pcpf_out_queue.sv
`timescale 1ns / 1ps
// Result queue of the pad cluster peak finder: takes up to two result items per
// cycle, hands out one per cycle while rsp_ready is high. Depends on pcpf_pkg.
module pcpf_out_queue #(
   parameter int OUT_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcpf_pkg::push_type      push,
   output logic                    room_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pcpf_pkg::rsp_item_type  rsp_item
);

   localparam int PTR_BITS   = $clog2(OUT_DEPTH);
   localparam int COUNT_BITS = $clog2(OUT_DEPTH + 1);

   pcpf_pkg::rsp_item_type  slot_ff [OUT_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_next;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    pop;

   assign rsp_valid   = count_ff != '0;
   assign rsp_item    = slot_ff[rd_ptr_ff];
   assign pop         = rsp_valid & rsp_ready;
   assign room_ok     = (COUNT_BITS'(OUT_DEPTH) - count_ff) >= COUNT_BITS'(2);
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign wr_ptr_in   = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in    = count_ff + COUNT_BITS'(push.count) - COUNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

FILE: verif/pad_cluster_peak_finder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pad cluster peak finder: directed and random pad hits,
// predicted cluster and peak results checked item by item. Depends on pcpf_pkg and the
// pad_cluster_peak_finder RTL.
module pad_cluster_peak_finder_tb;

   class peak_scoreboard;
      logic [pcpf_pkg::CHARGE_BITS-1:0]  threshold = '0;
      bit                                multi_hit = 1'b1;
      bit                                open_valid = 1'b0;
      logic [pcpf_pkg::ID_BITS-1:0]      cur_id = '0;
      logic [pcpf_pkg::ROW_COL_BITS-1:0] cur_row = '0;
      logic [pcpf_pkg::ROW_COL_BITS-1:0] cur_col = '0;
      logic [pcpf_pkg::CHARGE_BITS-1:0]  cur_charge = '0;
      bit                                prev_valid = 1'b0;
      logic [pcpf_pkg::ID_BITS-1:0]      prev_id = '0;
      logic [pcpf_pkg::CHARGE_BITS-1:0]  prev_charge = '0;
      bit                                rising = 1'b1;
      logic [pcpf_pkg::COUNT_BITS-1:0]   run_count = '0;
      logic [pcpf_pkg::SUM_BITS-1:0]     run_sum = '0;
      logic [pcpf_pkg::CHARGE_BITS-1:0]  run_max = '0;
      logic [pcpf_pkg::ID_BITS-1:0]      lead_ids [pcpf_pkg::KEEP_IDS];
      pcpf_pkg::rsp_item_type            step_results [$];
      pcpf_pkg::rsp_item_type            awaited_clusters [$];
      int                                errors = 0;

      function logic [pcpf_pkg::SUM_BITS-1:0] clip_sum(logic [pcpf_pkg::SUM_BITS-1:0] a,
                                                       logic [pcpf_pkg::SUM_BITS-1:0] b);
         logic [pcpf_pkg::SUM_BITS:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[pcpf_pkg::SUM_BITS] ? '1 : s[pcpf_pkg::SUM_BITS-1:0];
      endfunction

      function void emit(int cnt, logic [pcpf_pkg::ID_BITS-1:0] a,
                         logic [pcpf_pkg::ID_BITS-1:0] b, logic [pcpf_pkg::ID_BITS-1:0] c,
                         logic [pcpf_pkg::SUM_BITS-1:0] total,
                         logic [pcpf_pkg::CHARGE_BITS-1:0] peak);
         pcpf_pkg::rsp_item_type r;
         r.pad_count    = pcpf_pkg::COUNT_BITS'(cnt);
         r.first_id     = a;
         r.second_id    = b;
         r.third_id     = c;
         r.charge_total = total;
         r.charge_peak  = peak;
         r.last_result  = 1'b0;
         step_results.insert(step_results.size(), r);
      endfunction

      function void close_cluster();
         if (!open_valid) return;
         if (multi_hit) begin
            if (rising) begin
               if (prev_valid)
                  emit(2, prev_id, cur_id, '0, clip_sum(prev_charge, cur_charge), cur_charge);
               else
                  emit(1, cur_id, '0, '0, pcpf_pkg::SUM_BITS'(cur_charge), cur_charge);
            end
         end else begin
            emit(int'(run_count), lead_ids[0], (run_count >= 2) ? lead_ids[1] : '0,
                 (run_count >= 3) ? lead_ids[2] : '0, run_sum, run_max);
         end
         open_valid = 1'b0;
      endfunction

      function void open_cluster(logic [pcpf_pkg::ID_BITS-1:0] id,
                                 logic [pcpf_pkg::ROW_COL_BITS-1:0] row,
                                 logic [pcpf_pkg::ROW_COL_BITS-1:0] col,
                                 logic [pcpf_pkg::CHARGE_BITS-1:0] q);
         open_valid  = 1'b1;
         cur_id      = id;
         cur_row     = row;
         cur_col     = col;
         cur_charge  = q;
         prev_valid  = 1'b0;
         prev_id     = '0;
         prev_charge = '0;
         rising      = 1'b1;
         run_count   = 1;
         run_sum     = pcpf_pkg::SUM_BITS'(q);
         run_max     = q;
         lead_ids[0] = id;
         lead_ids[1] = '0;
         lead_ids[2] = '0;
      endfunction

      function void extend_cluster(logic [pcpf_pkg::ID_BITS-1:0] id,
                                   logic [pcpf_pkg::CHARGE_BITS-1:0] q);
         logic [pcpf_pkg::SUM_BITS-1:0] total;
         if (multi_hit && rising && q <= cur_charge) begin
            total = clip_sum(pcpf_pkg::SUM_BITS'(cur_charge), pcpf_pkg::SUM_BITS'(q));
            if (prev_valid)
               emit(3, prev_id, cur_id, id,
                    clip_sum(total, pcpf_pkg::SUM_BITS'(prev_charge)), cur_charge);
            else
               emit(2, cur_id, id, '0, total, cur_charge);
         end
         rising      = (q >= cur_charge);
         prev_valid  = 1'b1;
         prev_id     = cur_id;
         prev_charge = cur_charge;
         cur_id      = id;
         cur_col     = cur_col + 1'b1;
         cur_charge  = q;
         if (run_count < pcpf_pkg::KEEP_IDS) lead_ids[run_count] = id;
         if (run_count != pcpf_pkg::COUNT_MAX) run_count++;
         run_sum = clip_sum(run_sum, pcpf_pkg::SUM_BITS'(q));
         if (q > run_max) run_max = q;
      endfunction

      function void note_hit(pcpf_pkg::req_item_type hit);
         pcpf_pkg::rsp_item_type r;
         step_results.delete();
         if (hit.pad_charge > threshold) begin
            if (open_valid && hit.pad_row == cur_row &&
                {1'b0, hit.pad_col} == {1'b0, cur_col} + 1'b1) begin
               extend_cluster(hit.pad_id, hit.pad_charge);
            end else begin
               close_cluster();
               open_cluster(hit.pad_id, hit.pad_row, hit.pad_col, hit.pad_charge);
            end
         end
         if (hit.module_end) close_cluster();
         foreach (step_results[i]) begin
            r = step_results[i];
            r.last_result = (i == step_results.size() - 1);
            awaited_clusters.insert(awaited_clusters.size(), r);
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 100) $error("%s: expected %0h, got %0h", field, want, got);
         end
      endfunction

      function void check_result(pcpf_pkg::rsp_item_type got);
         pcpf_pkg::rsp_item_type want;
         if (awaited_clusters.size() == 0) begin
            errors++;
            if (errors <= 100) $error("result item with none awaited: %p", got);
            return;
         end
         want = awaited_clusters.pop_front();
         compare_field("pad_count", 32'(want.pad_count), 32'(got.pad_count));
         compare_field("first_id", 32'(want.first_id), 32'(got.first_id));
         compare_field("second_id", 32'(want.second_id), 32'(got.second_id));
         compare_field("third_id", 32'(want.third_id), 32'(got.third_id));
         compare_field("charge_total", 32'(want.charge_total), 32'(got.charge_total));
         compare_field("charge_peak", 32'(want.charge_peak), 32'(got.charge_peak));
         compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
      endfunction

      function int pending();
         return awaited_clusters.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   pcpf_pkg::req_item_type           req_item = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   pcpf_pkg::rsp_item_type           rsp_item;
   logic                             csr_wen = 1'b0;
   logic                             csr_index = 1'b0;
   logic [pcpf_pkg::CHARGE_BITS-1:0] csr_wdata = '0;

   peak_scoreboard board = new;
   int unsigned    send_idle_pct = 22;
   int unsigned    recv_stall_pct = 77;
   bit             hold_request = 1'b0;

   pad_cluster_peak_finder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_item);
   end

   function automatic pcpf_pkg::req_item_type make_hit(int id, int row, int col, int q,
                                                       bit last);
      pcpf_pkg::req_item_type hit;
      hit.pad_id     = pcpf_pkg::ID_BITS'(id);
      hit.pad_row    = pcpf_pkg::ROW_COL_BITS'(row);
      hit.pad_col    = pcpf_pkg::ROW_COL_BITS'(col);
      hit.pad_charge = pcpf_pkg::CHARGE_BITS'(q);
      hit.module_end = last;
      return hit;
   endfunction

   function automatic logic [pcpf_pkg::CHARGE_BITS-1:0] kept_charge();
      int unsigned span;
      int unsigned pick;
      span = 32'hFF_FFFF - 32'(board.threshold);
      if (span == 0) return '1;
      pick = $urandom_range(99);
      if (pick < 40)
         return pcpf_pkg::CHARGE_BITS'(board.threshold
                                       + $urandom_range(1, (span < 4) ? span : 4));
      if (pick < 85)
         return pcpf_pkg::CHARGE_BITS'(board.threshold + $urandom_range(1, span));
      if (pick < 93) return '1;
      return board.threshold + 1'b1;
   endfunction

   task automatic send_hit(input pcpf_pkg::req_item_type hit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= hit;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      board.note_hit(hit);
   endtask

   task automatic write_csr(input logic idx, input logic [pcpf_pkg::CHARGE_BITS-1:0] value);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == pcpf_pkg::CSR_THRESHOLD) board.threshold = value;
      else board.multi_hit = value[0];
   endtask

   task automatic send_modules(input int wanted, input int long_runs);
      pcpf_pkg::req_item_type            hit;
      int                                sent;
      int                                clusters;
      int                                len;
      logic [pcpf_pkg::ID_BITS-1:0]      next_id;
      logic [pcpf_pkg::ROW_COL_BITS-1:0] row;
      logic [pcpf_pkg::ROW_COL_BITS-1:0] col;
      sent = 0;
      while (sent < wanted) begin
         next_id  = pcpf_pkg::ID_BITS'($urandom);
         row      = pcpf_pkg::ROW_COL_BITS'($urandom);
         col      = pcpf_pkg::ROW_COL_BITS'($urandom);
         clusters = $urandom_range(1, 5);
         for (int c = 0; c < clusters; c++) begin
            if (long_runs > 0 && c == 0) begin
               long_runs--;
               len = 1 << pcpf_pkg::ROW_COL_BITS;
               col = '0;
            end else begin
               len = $urandom_range(1, 8);
            end
            for (int p = 0; p < len; p++) begin
               if (p > 0 && len < 256 && $urandom_range(99) < 3) col = col - 1'b1;
               hit.pad_id     = ($urandom_range(99) < 5) ? pcpf_pkg::ID_BITS'($urandom)
                                                         : next_id;
               hit.pad_row    = row;
               hit.pad_col    = col;
               hit.pad_charge = ($urandom_range(99) < 4 && len < 256)
                                ? pcpf_pkg::CHARGE_BITS'($urandom_range(0, board.threshold))
                                : kept_charge();
               hit.module_end = (c == clusters - 1 && p == len - 1) ||
                                ($urandom_range(99) < 2);
               send_hit(hit);
               if (hit.pad_charge > board.threshold || hit.module_end) sent++;
               next_id = next_id + 1'b1;
               col = col + 1'b1;
            end
            if ($urandom_range(1)) begin
               col = col + pcpf_pkg::ROW_COL_BITS'($urandom_range(1, 3));
            end else begin
               row = row + pcpf_pkg::ROW_COL_BITS'($urandom_range(1, 3));
               col = pcpf_pkg::ROW_COL_BITS'($urandom);
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_csr(pcpf_pkg::CSR_THRESHOLD, '0);
      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(1));
      send_hit(make_hit(0, 0, 0, 24'hFF_FFFF, 1));
      send_hit(make_hit(1, 1, 5, 10, 0));
      send_hit(make_hit(2, 1, 6, 30, 0));
      send_hit(make_hit(3, 1, 7, 20, 0));
      send_hit(make_hit(4, 1, 8, 5, 1));
      send_hit(make_hit(5, 2, 0, 50, 0));
      send_hit(make_hit(6, 2, 1, 50, 0));
      send_hit(make_hit(7, 2, 2, 50, 1));
      send_hit(make_hit(8, 3, 10, 7, 0));
      send_hit(make_hit(9, 3, 11, 0, 1));
      send_hit(make_hit(10, 4, 255, 9, 0));
      send_hit(make_hit(11, 4, 0, 9, 0));
      send_hit(make_hit(12, 5, 0, 9, 1));
      send_hit(make_hit(13, 6, 3, 100, 0));
      send_hit(make_hit(14, 6, 3, 100, 1));
      send_hit(make_hit(15, 7, 1, 5, 0));
      send_hit(make_hit(16, 8, 1, 6, 1));
      send_hit(make_hit(17, 9, 0, 10, 0));
      send_hit(make_hit(18, 9, 1, 20, 0));

      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(0));
      send_hit(make_hit(19, 9, 2, 15, 1));
      send_hit(make_hit(16'hFFFF, 255, 7, 24'hFF_FFFF, 1));
      send_hit(make_hit(20, 11, 0, 3, 0));
      send_hit(make_hit(21, 11, 1, 24'h80_0000, 0));
      send_hit(make_hit(22, 11, 2, 1, 0));
      send_hit(make_hit(23, 11, 3, 24'hFF_FFFF, 1));

      write_csr(pcpf_pkg::CSR_THRESHOLD, pcpf_pkg::CHARGE_BITS'($urandom_range(0, 1000)));
      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(1));
      hold_request = 1'b1;
      send_modules(60, 0);
      write_csr(pcpf_pkg::CSR_THRESHOLD, '1);
      send_modules(4, 0);

      send_idle_pct  = 77;
      recv_stall_pct = 22;
      write_csr(pcpf_pkg::CSR_THRESHOLD, '0);
      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(0));
      send_modules(120, 1);
      write_csr(pcpf_pkg::CSR_THRESHOLD, 24'hFF_FFFE);
      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(1));
      send_modules(30, 0);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(pcpf_pkg::CSR_THRESHOLD,
                pcpf_pkg::CHARGE_BITS'($urandom_range(0, 24'h80_0000)));
      hold_request = 1'b1;
      send_modules(40, 0);
      write_csr(pcpf_pkg::CSR_THRESHOLD, '0);
      write_csr(pcpf_pkg::CSR_MULTI_HIT, pcpf_pkg::CHARGE_BITS'(0));
      send_modules(30, 0);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
